[sv/vector3_fixed_point_unit_defines.svh]
// Assertion macros shared by the vector unit's checker.
// Depends on nothing; expects clk and rst_n in the scope of each use.
`ifndef VECTOR3_FIXED_POINT_UNIT_DEFINES_SVH
`define VECTOR3_FIXED_POINT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define VFU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define VFU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/vfu_pkg.sv]
// Shared types and constants of the 3-vector fixed point unit.
// Depends on nothing; used by the top level and its checker.
package vfu_pkg;

  localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_SCALE = 3'd2,
    OP_NORM  = 3'd3,
    OP_CROSS = 3'd4,
    OP_DOT   = 3'd5,
    OP_MAG   = 3'd6,
    OP_DIST  = 3'd7
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] scale_factor;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [31:0] scalar_result;
    logic               zero_length;
    logic               overflow;
  } out_item_t;

endpackage

[sv/vector3_fixed_point_unit.sv]
// Top level of the 3-vector fixed point unit; uses vfu_pkg for item types and op codes.
// The unit takes one item (op, vectors a and b, scalar k, all signed fixed point with
// FRAC_BITS fractional bits) and returns one result item: add, sub, scale, normalize,
// cross, dot, magnitude or distance. Results that do not fit 32 bits saturate and set
// overflow; normalizing the zero vector gives zeros and sets zero_length. The datapath
// is a fixed pipeline of FRAC_BITS+40 register stages (56 at the default of 16): five
// front stages (add/sub, normalizing shift, six shared 33x33 multipliers, sums,
// rounding), 32 stages of a restoring square root (one root bit per stage), one stage
// to form the dividends, FRAC_BITS+1 stages of a restoring divider (one quotient bit per
// stage, three lanes) and the output register. Every item walks the whole pipeline, for
// every op, and a new item is taken every cycle while the pipeline is not held.
// in_stall rises only while a finished result sits in the output register and out_stall
// is high; the whole pipeline then holds.
module vector3_fixed_point_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  vfu_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output vfu_pkg::out_item_t out_data
);

  localparam int unsigned SQ_N = 32;              // root bits, one per stage
  localparam int unsigned DV_N = FRAC_BITS + 1;   // quotient bits, one per stage
  localparam int unsigned NW   = 33 + FRAC_BITS;  // dividend width
  localparam logic signed [69:0] RND_HALF = 70'(1) << (FRAC_BITS - 1);

  // Item state that rides along with the arithmetic.
  typedef struct packed {
    vfu_pkg::op_t     op;
    logic [2:0][31:0] rv;    // vector result where already known
    logic [31:0]      sc;    // scalar result where already known
    logic             zl;
    logic             ovf;
    logic [2:0]       neg;   // signs of a, for normalize
    logic [2:0][31:0] u;     // shifted magnitudes of a, for normalize
  } carry_t;

  function automatic logic signed [32:0] sx33(input logic [31:0] v);
    return {v[31], v};
  endfunction

  // Saturate a 70-bit value to 32 bits; top bit of the result is the overflow flag.
  function automatic logic [32:0] sat70(input logic signed [69:0] x);
    logic fits;
    fits = (&x[69:31]) || !(|x[69:31]);
    if (fits) return {1'b0, x[31:0]};
    return {1'b1, x[69] ? vfu_pkg::SAT_MIN : vfu_pkg::SAT_MAX};
  endfunction

  // Add half an LSB, drop FRAC_BITS fraction bits, saturate.
  function automatic logic [32:0] rnd_sat(input logic signed [69:0] x);
    logic signed [69:0] s;
    s = x + RND_HALF;
    return sat70(s >>> FRAC_BITS);
  endfunction

  // The whole pipeline advances unless a result waits at a stalled output.
  logic adv;
  logic out_valid_r;
  vfu_pkg::out_item_t out_data_r;

  assign adv       = !(out_valid_r && out_stall);
  assign in_stall  = !adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------- stage 1
  // Add/sub with saturation, absolute values and largest magnitude of a,
  // and the operands of the sum of squares.
  logic signed [31:0] in_a [3];
  logic signed [31:0] in_b [3];

  carry_t             s1_c_nxt, s1_c_r;
  logic               s1_v_r;
  logic signed [31:0] s1_a_r [3];
  logic signed [31:0] s1_b_r [3];
  logic signed [31:0] s1_k_r;
  logic [31:0]        s1_abs_nxt [3];
  logic [31:0]        s1_abs_r [3];
  logic [31:0]        s1_max_nxt, s1_max_r;
  logic signed [32:0] s1_d_nxt [3];
  logic signed [32:0] s1_d_r [3];

  always_comb begin
    in_a[0] = in_data.a_x;
    in_a[1] = in_data.a_y;
    in_a[2] = in_data.a_z;
    in_b[0] = in_data.b_x;
    in_b[1] = in_data.b_y;
    in_b[2] = in_data.b_z;
  end

  always_comb begin
    logic signed [32:0] s;
    logic               o;
    s1_c_nxt    = '0;
    s1_c_nxt.op = in_data.op;
    s1_max_nxt  = '0;
    for (int i = 0; i < 3; i++) begin
      s = (in_data.op == vfu_pkg::OP_SUB) ? (sx33(in_a[i]) - sx33(in_b[i]))
                                          : (sx33(in_a[i]) + sx33(in_b[i]));
      o = s[32] ^ s[31];
      if (in_data.op == vfu_pkg::OP_ADD || in_data.op == vfu_pkg::OP_SUB) begin
        s1_c_nxt.rv[i] = o ? (s[32] ? vfu_pkg::SAT_MIN : vfu_pkg::SAT_MAX) : s[31:0];
        s1_c_nxt.ovf   = s1_c_nxt.ovf | o;
      end
      s1_c_nxt.neg[i] = in_a[i][31];
      s1_abs_nxt[i]   = in_a[i][31] ? (32'd0 - in_a[i]) : in_a[i];
      if (s1_abs_nxt[i] > s1_max_nxt) s1_max_nxt = s1_abs_nxt[i];
      s1_d_nxt[i] = (in_data.op == vfu_pkg::OP_DIST) ? (sx33(in_b[i]) - sx33(in_a[i]))
                                                     : sx33(in_a[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_c_r   <= s1_c_nxt;
      s1_a_r   <= in_a;
      s1_b_r   <= in_b;
      s1_k_r   <= in_data.scale_factor;
      s1_abs_r <= s1_abs_nxt;
      s1_max_r <= s1_max_nxt;
      s1_d_r   <= s1_d_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // Normalizing shift of a, then pick the six multiplier operand pairs.
  // Pairs 2i and 2i+1 feed result lane i as p[2i] - p[2i+1].
  carry_t             s2_c_nxt, s2_c_r;
  logic               s2_v_r;
  logic signed [32:0] s2_x_nxt [6];
  logic signed [32:0] s2_y_nxt [6];
  logic signed [32:0] s2_x_r [6];
  logic signed [32:0] s2_y_r [6];

  always_comb begin
    logic [31:0] mm1;
    logic [5:0]  lz;
    logic [4:0]  sh;
    mm1 = s1_max_r - 32'd1;
    lz  = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (mm1[i]) lz = 6'(31 - i);
    end
    sh = 5'(lz - 6'd1);

    s2_c_nxt    = s1_c_r;
    s2_c_nxt.zl = (s1_c_r.op == vfu_pkg::OP_NORM) && (s1_max_r == 32'd0);
    for (int i = 0; i < 3; i++) begin
      s2_c_nxt.u[i] = (s1_c_r.op == vfu_pkg::OP_NORM) ? (s1_abs_r[i] << sh) : 32'd0;
    end

    for (int j = 0; j < 6; j++) begin
      s2_x_nxt[j] = '0;
      s2_y_nxt[j] = '0;
    end
    unique case (s1_c_r.op) inside
      vfu_pkg::OP_ADD, vfu_pkg::OP_SUB: begin
      end
      vfu_pkg::OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          s2_x_nxt[2*i] = sx33(s1_a_r[i]);
          s2_y_nxt[2*i] = sx33(s1_k_r);
        end
      end
      vfu_pkg::OP_CROSS: begin
        s2_x_nxt[0] = sx33(s1_a_r[1]);  s2_y_nxt[0] = sx33(s1_b_r[2]);
        s2_x_nxt[1] = sx33(s1_a_r[2]);  s2_y_nxt[1] = sx33(s1_b_r[1]);
        s2_x_nxt[2] = sx33(s1_a_r[2]);  s2_y_nxt[2] = sx33(s1_b_r[0]);
        s2_x_nxt[3] = sx33(s1_a_r[0]);  s2_y_nxt[3] = sx33(s1_b_r[2]);
        s2_x_nxt[4] = sx33(s1_a_r[0]);  s2_y_nxt[4] = sx33(s1_b_r[1]);
        s2_x_nxt[5] = sx33(s1_a_r[1]);  s2_y_nxt[5] = sx33(s1_b_r[0]);
      end
      vfu_pkg::OP_DOT: begin
        for (int i = 0; i < 3; i++) begin
          s2_x_nxt[2*i] = sx33(s1_a_r[i]);
          s2_y_nxt[2*i] = sx33(s1_b_r[i]);
        end
      end
      vfu_pkg::OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          s2_x_nxt[2*i] = {1'b0, s2_c_nxt.u[i]};
          s2_y_nxt[2*i] = {1'b0, s2_c_nxt.u[i]};
        end
      end
      vfu_pkg::OP_MAG, vfu_pkg::OP_DIST: begin
        for (int i = 0; i < 3; i++) begin
          s2_x_nxt[2*i] = s1_d_r[i];
          s2_y_nxt[2*i] = s1_d_r[i];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_c_r <= s2_c_nxt;
      s2_x_r <= s2_x_nxt;
      s2_y_r <= s2_y_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // Six signed 33x33 products.
  carry_t             s3_c_r;
  logic               s3_v_r;
  logic signed [65:0] s3_p_nxt [6];
  logic signed [65:0] s3_p_r [6];

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      s3_p_nxt[j] = s2_x_r[j] * s2_y_r[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_c_r <= s2_c_r;
      s3_p_r <= s3_p_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // Lane differences and the three-term sum (dot product or sum of squares).
  carry_t             s4_c_r;
  logic               s4_v_r;
  logic signed [66:0] s4_t_nxt [3];
  logic signed [66:0] s4_t_r [3];
  logic signed [68:0] s4_sum_nxt, s4_sum_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s4_t_nxt[i] = {s3_p_r[2*i][65], s3_p_r[2*i]} - {s3_p_r[2*i+1][65], s3_p_r[2*i+1]};
    end
    s4_sum_nxt = {{2{s4_t_nxt[0][66]}}, s4_t_nxt[0]}
               + {{2{s4_t_nxt[1][66]}}, s4_t_nxt[1]}
               + {{2{s4_t_nxt[2][66]}}, s4_t_nxt[2]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_c_r   <= s3_c_r;
      s4_t_r   <= s4_t_nxt;
      s4_sum_r <= s4_sum_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 5
  // Round and saturate scale, cross and dot; flag roots that cannot fit
  // (sum of squares at or above 2^62) and hand the radicand to the root.
  logic               sq_v_r    [SQ_N+1];
  carry_t             sq_c_r    [SQ_N+1];
  logic [63:0]        sq_rad_r  [SQ_N+1];
  logic [33:0]        sq_rem_r  [SQ_N+1];
  logic [31:0]        sq_root_r [SQ_N+1];
  carry_t             s5_c_nxt;

  always_comb begin
    logic [32:0] rs;
    s5_c_nxt = s4_c_r;
    rs       = '0;
    unique case (s4_c_r.op) inside
      vfu_pkg::OP_SCALE, vfu_pkg::OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          rs = rnd_sat({{3{s4_t_r[i][66]}}, s4_t_r[i]});
          s5_c_nxt.rv[i] = rs[31:0];
          s5_c_nxt.ovf   = s5_c_nxt.ovf | rs[32];
        end
      end
      vfu_pkg::OP_DOT: begin
        rs = rnd_sat({s4_sum_r[68], s4_sum_r});
        s5_c_nxt.sc  = rs[31:0];
        s5_c_nxt.ovf = rs[32];
      end
      vfu_pkg::OP_MAG, vfu_pkg::OP_DIST: begin
        s5_c_nxt.ovf = |s4_sum_r[68:62];
      end
      vfu_pkg::OP_ADD, vfu_pkg::OP_SUB, vfu_pkg::OP_NORM: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (adv) begin
      sq_v_r[0] <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_c_r[0]    <= s5_c_nxt;
      sq_rad_r[0]  <= s4_sum_r[63:0];
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
    end
  end

  // ---------------------------------------------------------------- root
  // Restoring square root, two radicand bits in and one root bit out per stage.
  for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
    logic [35:0] rem_cat;
    logic [35:0] trial;
    logic        take;
    logic [33:0] rem_nxt;
    logic [31:0] root_nxt;

    assign rem_cat  = {sq_rem_r[j], sq_rad_r[j][63:62]};
    assign trial    = {2'b00, sq_root_r[j], 2'b01};
    assign take     = (rem_cat >= trial);
    assign rem_nxt  = take ? 34'(rem_cat - trial) : rem_cat[33:0];
    assign root_nxt = {sq_root_r[j][30:0], take};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[j+1] <= 1'b0;
      end else if (adv) begin
        sq_v_r[j+1] <= sq_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_c_r[j+1]    <= sq_c_r[j];
        sq_rad_r[j+1]  <= {sq_rad_r[j][61:0], 2'b00};
        sq_rem_r[j+1]  <= rem_nxt;
        sq_root_r[j+1] <= root_nxt;
      end
    end
  end

  // ---------------------------------------------------------------- dividends
  // Dividend of lane i is u_i * 2^FRAC_BITS + floor(mag / 2); the quotient
  // stays below 2^DV_N, so the top bits start as the partial remainder.
  logic                      dv_v_r   [DV_N+1];
  carry_t                    dv_c_r   [DV_N+1];
  logic [31:0]               dv_mag_r [DV_N+1];
  logic [2:0][31:0]          dv_rem_r [DV_N+1];
  logic [2:0][DV_N-1:0]      dv_low_r [DV_N+1];
  logic [2:0][DV_N-1:0]      dv_q_r   [DV_N+1];
  logic [2:0][31:0]          dv0_rem_nxt;
  logic [2:0][DV_N-1:0]      dv0_low_nxt;

  always_comb begin
    logic [NW-1:0] num;
    for (int i = 0; i < 3; i++) begin
      num = ({{(NW-32){1'b0}}, sq_c_r[SQ_N].u[i]} << FRAC_BITS)
          + {{(NW-31){1'b0}}, sq_root_r[SQ_N][31:1]};
      dv0_rem_nxt[i] = num[NW-1:DV_N];
      dv0_low_nxt[i] = num[DV_N-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= sq_v_r[SQ_N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_c_r[0]   <= sq_c_r[SQ_N];
      dv_mag_r[0] <= sq_root_r[SQ_N];
      dv_rem_r[0] <= dv0_rem_nxt;
      dv_low_r[0] <= dv0_low_nxt;
      dv_q_r[0]   <= '0;
    end
  end

  // ---------------------------------------------------------------- divider
  // Restoring division by the root, three lanes, one quotient bit per stage.
  for (genvar j = 0; j < DV_N; j++) begin : g_div
    logic [2:0][31:0]     rem_nxt;
    logic [2:0][DV_N-1:0] q_nxt;
    logic [2:0][DV_N-1:0] low_nxt;

    always_comb begin
      logic [32:0] rc;
      logic        take;
      for (int i = 0; i < 3; i++) begin
        rc         = {dv_rem_r[j][i], dv_low_r[j][i][DV_N-1]};
        take       = (rc >= {1'b0, dv_mag_r[j]});
        rem_nxt[i] = take ? 32'(rc - {1'b0, dv_mag_r[j]}) : rc[31:0];
        q_nxt[i]   = {dv_q_r[j][i][DV_N-2:0], take};
        low_nxt[i] = {dv_low_r[j][i][DV_N-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else if (adv) begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_c_r[j+1]   <= dv_c_r[j];
        dv_mag_r[j+1] <= dv_mag_r[j];
        dv_rem_r[j+1] <= rem_nxt;
        dv_low_r[j+1] <= low_nxt;
        dv_q_r[j+1]   <= q_nxt;
      end
    end
  end

  // ---------------------------------------------------------------- output
  // Assemble the result item: signed quotients for normalize, the clamped
  // root for magnitude and distance, the carried values otherwise.
  carry_t             oc;
  vfu_pkg::out_item_t out_data_nxt;

  assign oc = dv_c_r[DV_N];

  always_comb begin
    logic [31:0] q32;
    logic [2:0][31:0] rv;
    logic [31:0] sc;
    rv  = '0;
    sc  = '0;
    q32 = '0;
    out_data_nxt = '0;
    unique case (oc.op) inside
      vfu_pkg::OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          q32   = {{(32-DV_N){1'b0}}, dv_q_r[DV_N][i]};
          rv[i] = oc.zl ? 32'd0 : (oc.neg[i] ? (32'd0 - q32) : q32);
        end
        out_data_nxt.zero_length = oc.zl;
      end
      vfu_pkg::OP_MAG, vfu_pkg::OP_DIST: begin
        sc = oc.ovf ? vfu_pkg::SAT_MAX : dv_mag_r[DV_N];
        out_data_nxt.overflow = oc.ovf;
      end
      vfu_pkg::OP_ADD, vfu_pkg::OP_SUB, vfu_pkg::OP_SCALE,
      vfu_pkg::OP_CROSS, vfu_pkg::OP_DOT: begin
        rv = oc.rv;
        sc = oc.sc;
        out_data_nxt.overflow = oc.ovf;
      end
    endcase
    out_data_nxt.r_x           = rv[0];
    out_data_nxt.r_y           = rv[1];
    out_data_nxt.r_z           = rv[2];
    out_data_nxt.scalar_result = sc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_v_r[DV_N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

[sv/vfu_chk.sv]
// Port-level checker for the 3-vector fixed point unit, bound to the top level.
// Depends on vfu_pkg and vector3_fixed_point_unit_defines.svh.
`include "vector3_fixed_point_unit_defines.svh"

module vfu_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input vfu_pkg::out_item_t out_data
);

  logic vec_zero;

  assign vec_zero = (out_data.r_x == 32'd0) && (out_data.r_y == 32'd0) &&
                    (out_data.r_z == 32'd0);

  // Hold a stalled result.
  `VFU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  // Stall the input only behind a stalled result.
  `VFU_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without output stall")

  // A zero vector to normalize gives all zeros and no overflow.
  `VFU_ASSERT_NOW(a_zero_len, out_valid && out_data.zero_length, vec_zero && !out_data.overflow && (out_data.scalar_result == 32'd0), "zero length result not clean")

  // A result is a vector or a scalar and never both.
  `VFU_ASSERT_NOW(a_one_kind, out_valid, vec_zero || (out_data.scalar_result == 32'd0), "vector and scalar both set")

endmodule

bind vector3_fixed_point_unit vfu_chk u_vfu_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[tb/sv/tb_top.sv]
// Self-checking bench for vector3_fixed_point_unit: directed table, then random items.
// Depends on vfu_pkg and the unit's RTL; carries its own bit-exact predictor of every op.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC       = 16;
  localparam int LATENCY    = FRAC + 40;
  localparam int RAND_ITEMS = 1700;
  localparam logic [31:0] ONE     = 32'h0001_0000;
  localparam logic [31:0] SAT_MAX = vfu_pkg::SAT_MAX;
  localparam logic [31:0] SAT_MIN = vfu_pkg::SAT_MIN;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  vfu_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  vfu_pkg::out_item_t out_data;

  vector3_fixed_point_unit #(.FRAC_BITS(FRAC)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #10 clk = ~clk;

  // Results still owed by the unit, oldest first.
  vfu_pkg::out_item_t owed_results[$];
  int                 n_items_taken = 0;
  int                 n_results_taken = 0;
  int                 n_errors = 0;
  // A directed row with a typed result overrides the predictor for that item.
  bit                 row_typed = 1'b0;
  vfu_pkg::out_item_t row_result = '0;
  bit                 calm = 1'b0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Clamp an exact value to 32 bits; raise the flag when it does not fit.
  function automatic logic [31:0] clamp32(input logic signed [127:0] w, inout logic ovf);
    if (w > 128'sh7fff_ffff) begin
      ovf = 1'b1;
      return SAT_MAX;
    end
    if (w < -128'sh8000_0000) begin
      ovf = 1'b1;
      return SAT_MIN;
    end
    return w[31:0];
  endfunction

  // Round half up at the binary point, drop the extra fraction bits.
  function automatic logic signed [127:0] rnd(input logic signed [127:0] w);
    return (w + (128'sd1 <<< (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic logic signed [127:0] mul(input logic signed [31:0] x,
                                              input logic signed [31:0] y);
    logic signed [127:0] w;
    w = longint'(x) * longint'(y);
    return w;
  endfunction

  // Floor square root, one result bit at a time from the top.
  function automatic logic [63:0] root64(input logic [63:0] n);
    logic [63:0] res, t;
    res = 0;
    for (int i = 31; i >= 0; i--) begin
      t = res | (64'd1 << i);
      if (t * t <= n) res = t;
    end
    return res;
  endfunction

  // Root of the sum of squares; saturate when the sum or the root is too wide.
  function automatic logic [31:0] length3(input logic signed [63:0] d[3], inout logic ovf);
    logic [127:0] s;
    logic [63:0]  u, r;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      u = (d[i] < 0) ? -d[i] : d[i];
      s += 128'(u) * 128'(u);
    end
    if (s[127:64] != 0) begin
      ovf = 1'b1;
      return SAT_MAX;
    end
    r = root64(s[63:0]);
    if (r > 64'h7fff_ffff) begin
      ovf = 1'b1;
      return SAT_MAX;
    end
    return r[31:0];
  endfunction

  function automatic vfu_pkg::out_item_t predict_result(input vfu_pkg::in_item_t it);
    vfu_pkg::out_item_t o;
    logic signed [31:0] a[3], b[3];
    logic signed [63:0] d[3];
    logic [63:0] u[3], mx, s, mag, q;
    logic ovf;
    int sh;
    o = '0;
    ovf = 1'b0;
    a = '{it.a_x, it.a_y, it.a_z};
    b = '{it.b_x, it.b_y, it.b_z};
    case (it.op) inside
      vfu_pkg::OP_ADD, vfu_pkg::OP_SUB: begin
        for (int i = 0; i < 3; i++) begin
          d[i] = (it.op == vfu_pkg::OP_ADD) ? longint'(a[i]) + longint'(b[i])
                                            : longint'(a[i]) - longint'(b[i]);
        end
        o.r_x = clamp32(d[0], ovf);
        o.r_y = clamp32(d[1], ovf);
        o.r_z = clamp32(d[2], ovf);
      end
      vfu_pkg::OP_SCALE: begin
        o.r_x = clamp32(rnd(mul(a[0], it.scale_factor)), ovf);
        o.r_y = clamp32(rnd(mul(a[1], it.scale_factor)), ovf);
        o.r_z = clamp32(rnd(mul(a[2], it.scale_factor)), ovf);
      end
      vfu_pkg::OP_NORM: begin
        mx = 0;
        for (int i = 0; i < 3; i++) begin
          d[i] = a[i];
          u[i] = (d[i] < 0) ? -d[i] : d[i];
          if (u[i] > mx) mx = u[i];
        end
        if (mx == 0) begin
          o.zero_length = 1'b1;
        end else begin
          sh = 0;
          while ((mx << 1) <= 64'h8000_0000) begin
            mx = mx << 1;
            sh++;
          end
          s = 0;
          for (int i = 0; i < 3; i++) begin
            u[i] = u[i] << sh;
            s += u[i] * u[i];
          end
          mag = root64(s);
          for (int i = 0; i < 3; i++) begin
            q = ((u[i] << FRAC) + (mag >> 1)) / mag;
            if (a[i] < 0) q = -q;
            u[i] = q;
          end
          o.r_x = u[0][31:0];
          o.r_y = u[1][31:0];
          o.r_z = u[2][31:0];
        end
      end
      vfu_pkg::OP_CROSS: begin
        o.r_x = clamp32(rnd(mul(a[1], b[2]) - mul(a[2], b[1])), ovf);
        o.r_y = clamp32(rnd(mul(a[2], b[0]) - mul(a[0], b[2])), ovf);
        o.r_z = clamp32(rnd(mul(a[0], b[1]) - mul(a[1], b[0])), ovf);
      end
      vfu_pkg::OP_DOT: begin
        o.scalar_result = clamp32(rnd(mul(a[0], b[0]) + mul(a[1], b[1])
                                      + mul(a[2], b[2])), ovf);
      end
      vfu_pkg::OP_MAG: begin
        for (int i = 0; i < 3; i++) d[i] = a[i];
        o.scalar_result = length3(d, ovf);
      end
      default: begin
        for (int i = 0; i < 3; i++) d[i] = longint'(b[i]) - longint'(a[i]);
        o.scalar_result = length3(d, ovf);
      end
    endcase
    o.overflow = ovf;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitors: sample both channels at the rising edge
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    n_errors++;
    $display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    vfu_pkg::out_item_t want;
    if (rst_n && in_valid && !in_stall) begin
      owed_results.push_back(row_typed ? row_result : predict_result(in_data));
      n_items_taken++;
    end
    if (rst_n && out_valid && !out_stall) begin
      n_results_taken++;
      if (owed_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(n_results_taken), 32'h0);
      end else begin
        want = owed_results.pop_front();
        if (out_data.r_x !== want.r_x) report_mismatch("r_x", out_data.r_x, want.r_x);
        if (out_data.r_y !== want.r_y) report_mismatch("r_y", out_data.r_y, want.r_y);
        if (out_data.r_z !== want.r_z) report_mismatch("r_z", out_data.r_z, want.r_z);
        if (out_data.scalar_result !== want.scalar_result)
          report_mismatch("scalar_result", out_data.scalar_result, want.scalar_result);
        if (out_data.zero_length !== want.zero_length)
          report_mismatch("zero_length", 32'(out_data.zero_length),
                          32'(want.zero_length));
        if (out_data.overflow !== want.overflow)
          report_mismatch("overflow", 32'(out_data.overflow), 32'(want.overflow));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: hold out_stall for a random count before each result
  // ---------------------------------------------------------------------------

  int stall_left = 0;
  int results_seen = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (n_results_taken != results_seen) begin
        results_seen = n_results_taken;
        stall_left = calm ? 0 : $urandom_range(0, 19);
      end
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // ---------------------------------------------------------------------------
  // Item side
  // ---------------------------------------------------------------------------

  // Drive one item at the falling edge and hold it until the unit takes it.
  task automatic send_item(input vfu_pkg::in_item_t it, input bit typed,
                           input vfu_pkg::out_item_t res);
    int gap, taken;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_data    <= it;
    row_typed  = typed;
    row_result = res;
    taken = n_items_taken;
    do @(negedge clk); while (n_items_taken == taken);
  endtask

  // Components: mostly small Q16.16 values, some extremes, some raw noise.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9)) inside
      0:       return SAT_MAX;
      1:       return SAT_MIN;
      2, 3:    return $urandom();
      4:       return $urandom_range(0, 3) - 1;
      default: return 32'($signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000);
    endcase
  endfunction

  typedef struct {
    vfu_pkg::in_item_t  it;
    bit                 typed;
    vfu_pkg::out_item_t res;
  } row_t;

  row_t rows[$];

  initial begin
    vfu_pkg::in_item_t  it;
    vfu_pkg::out_item_t none;
    none = '0;
    // Directed table: op, a, b, k and, where obvious, the result.
    rows = '{
      '{'{vfu_pkg::OP_ADD, 0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 0, 1'b0, 1'b0}},
      '{'{vfu_pkg::OP_ADD, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, 0}, 1,
        '{SAT_MAX, SAT_MAX, SAT_MAX, 0, 1'b0, 1'b1}},
      '{'{vfu_pkg::OP_SUB, SAT_MIN, SAT_MIN, SAT_MIN, 1, 1, 1, 0}, 1,
        '{SAT_MIN, SAT_MIN, SAT_MIN, 0, 1'b0, 1'b1}},
      '{'{vfu_pkg::OP_SUB, SAT_MAX, SAT_MIN, 5, SAT_MIN, SAT_MAX, -7, SAT_MAX},
        0, none},
      '{'{vfu_pkg::OP_SCALE, ONE, -ONE, SAT_MAX, 0, 0, 0, ONE}, 1,
        '{ONE, -ONE, SAT_MAX, 0, 1'b0, 1'b0}},
      '{'{vfu_pkg::OP_SCALE, 1, -1, 0, 0, 0, 0, 32'h8000}, 1,
        '{1, 0, 0, 0, 1'b0, 1'b0}},
      '{'{vfu_pkg::OP_SCALE, SAT_MIN, SAT_MAX, SAT_MIN, 0, 0, 0, SAT_MIN}, 0, none},
      '{'{vfu_pkg::OP_NORM, 0, 0, 0, 5, 6, 7, 8}, 1, '{0, 0, 0, 0, 1'b1, 1'b0}},
      '{'{vfu_pkg::OP_NORM, 3, 0, 0, 0, 0, 0, 0}, 1, '{ONE, 0, 0, 0, 1'b0, 1'b0}},
      '{'{vfu_pkg::OP_NORM, SAT_MIN, SAT_MIN, SAT_MIN, 0, 0, 0, 0}, 0, none},
      '{'{vfu_pkg::OP_NORM, SAT_MAX, -1, 1, 0, 0, 0, 0}, 0, none},
      '{'{vfu_pkg::OP_NORM, 3 * ONE, -4 * ONE, 12 * ONE, 0, 0, 0, 0}, 0, none},
      '{'{vfu_pkg::OP_CROSS, ONE, 0, 0, 0, ONE, 0, 0}, 1,
        '{0, 0, ONE, 0, 1'b0, 1'b0}},
      '{'{vfu_pkg::OP_CROSS, SAT_MIN, SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN, SAT_MIN, 0},
        0, none},
      '{'{vfu_pkg::OP_DOT, ONE, 2 * ONE, 3 * ONE, ONE, ONE, ONE, 0}, 1,
        '{0, 0, 0, 6 * ONE, 1'b0, 1'b0}},
      '{'{vfu_pkg::OP_DOT, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, 0},
        0, none},
      '{'{vfu_pkg::OP_DOT, SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN, 0},
        0, none},
      '{'{vfu_pkg::OP_MAG, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0}, 1,
        '{0, 0, 0, 5 * ONE, 1'b0, 1'b0}},
      '{'{vfu_pkg::OP_MAG, -1, -1, -1, 0, 0, 0, 0}, 1, '{0, 0, 0, 1, 1'b0, 1'b0}},
      '{'{vfu_pkg::OP_MAG, SAT_MIN, SAT_MIN, SAT_MIN, 0, 0, 0, 0}, 1,
        '{0, 0, 0, SAT_MAX, 1'b0, 1'b1}},
      '{'{vfu_pkg::OP_DIST, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MAX, SAT_MAX, SAT_MAX, 0}, 1,
        '{0, 0, 0, SAT_MAX, 1'b0, 1'b1}},
      '{'{vfu_pkg::OP_DIST, 17, -9, 4, 17, -9, 4, 0}, 1, '{0, 0, 0, 0, 1'b0, 1'b0}},
      '{'{vfu_pkg::OP_DIST, SAT_MIN, 0, 0, SAT_MAX, 0, 0, 0}, 0, none}
    };

    // Hold reset, then release it at a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].res);

    // Random items; every 200, pick anew (one chance in four) a run with no idling at all.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 200 == 0) calm = ($urandom_range(0, 3) == 0);
      it.op           = vfu_pkg::op_t'($urandom_range(0, 7));
      it.a_x          = pick_value();
      it.a_y          = pick_value();
      it.a_z          = pick_value();
      it.b_x          = pick_value();
      it.b_y          = pick_value();
      it.b_z          = pick_value();
      it.scale_factor = pick_value();
      send_item(it, 1'b0, none);
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    // Drain: wait for every owed result, then allow the pipeline depth once more.
    wait (owed_results.size() == 0);
    repeat (LATENCY + 8) @(negedge clk);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule

[vector3_fixed_point_unit.f]
+incdir+sv
sv/vfu_pkg.sv
sv/vector3_fixed_point_unit.sv
sv/vfu_chk.sv
tb/sv/tb_top.sv
